FILE: hw/rtl/amips_triangle_energy_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the triangle energy checker
// ---------------------------------------------------------------------------
`ifndef AMIPS_TRIANGLE_ENERGY_DEFINES_SVH
`define AMIPS_TRIANGLE_ENERGY_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define ATE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define ATE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ate_pkg.sv
// ---------------------------------------------------------------------------
// ate_pkg
// Types and constants of the AMIPS triangle energy pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ate_pkg;

    // Datapath widths
    localparam int unsigned EW = 33;   // edge component, signed
    localparam int unsigned PW = 66;   // edge product, signed
    localparam int unsigned NW = 67;   // numerator form N, unsigned
    localparam int unsigned DW = 66;   // |D|
    localparam int unsigned XW = 101;  // dividend (N*K + |D|*2^29) >> 30
    localparam int unsigned QW = 63;   // quotient bits below the overflow bit

    // 2^63 / sqrt(3), rounded
    localparam logic [62:0] INV_SQRT3_Q63 = 63'd5325116328314171701;

    localparam logic [63:0] ENERGY_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ENERGY_MIN = 64'h8000_0000_0000_0000;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_DEGEN = 2'd1,
        STATUS_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [31:0] vertex_a_x;
        logic signed [31:0] vertex_a_y;
        logic signed [31:0] vertex_b_x;
        logic signed [31:0] vertex_b_y;
        logic signed [31:0] vertex_c_x;
        logic signed [31:0] vertex_c_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [63:0] energy;
        t_status            status;
    } t_out_beat;

    // Front end to divider
    typedef struct packed {
        logic [XW-1:0] x;
        logic [DW-1:0] dmag;
        logic          inv;
        logic          zero;
    } t_front_beat;

    // One divider stage
    typedef struct packed {
        logic [DW-1:0] rem;
        logic [QW-1:0] xlo;
        logic [QW-1:0] q;
        logic [DW-1:0] dmag;
        logic          inv;
        logic          zero;
        logic          ovf;
    } t_div_beat;

endpackage

FILE: hw/rtl/amips_triangle_energy.sv
// ---------------------------------------------------------------------------
// amips_triangle_energy
// AMIPS distortion energy of one 2D triangle against a unit equilateral target.
// ---------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one triangle per beat, six
// signed Q16.16 vertex coordinates. Output channel: o_out_valid / i_out_ready
// carry the energy as signed Q32.32 and a status (ok, degenerate, saturated).
// A result passes through 71 register stages: six front stages (edges,
// products, N and D, partial products of N*K, partial sums, dividend),
// one overflow stage, 63 restoring divider stages, and the output
// register. Throughput is one triangle per cycle while the output does
// not stall; the divider's 63 registered trial subtracts set the pipe length.
// A stalled output freezes the whole pipe; the first stage still takes a
// beat while it is empty, so a waiting result and an incoming triangle do not
// block each other. Reset clears every valid bit; payload registers are left.
// The coordinate fraction width does not enter the arithmetic: it cancels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module amips_triangle_energy (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ate_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ate_pkg::t_out_beat o_out_data
);
    import ate_pkg::*;

    logic        w_en;
    logic        r_front_v0;
    logic        w_front_valid;
    t_front_beat w_front;
    logic        w_div_valid;
    t_div_beat   w_div;
    logic [63:0] w_mag;
    t_out_beat   n_out;
    logic        r_out_valid;
    t_out_beat   r_out;

    // Advance when the output register is free or being drained
    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en || !r_front_v0;

    ate_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (o_in_ready),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_beat  (i_in_data),
        .o_valid (w_front_valid),
        .o_beat  (w_front)
    );

    // Track occupancy of the first stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_v0 <= 1'b0;
        end else if (o_in_ready) begin
            r_front_v0 <= i_in_valid;
        end
    end

    ate_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_valid),
        .i_beat  (w_front),
        .o_valid (w_div_valid),
        .o_beat  (w_div)
    );

    // Apply sign, saturate, flag degenerate
    always_comb begin
        w_mag = {1'b0, w_div.q};
        if (w_div.zero) begin
            n_out.energy = ENERGY_MAX;
            n_out.status = STATUS_DEGEN;
        end else if (w_div.ovf) begin
            n_out.energy = w_div.inv ? ENERGY_MIN : ENERGY_MAX;
            n_out.status = STATUS_SAT;
        end else begin
            n_out.energy = w_div.inv ? -w_mag : w_mag;
            n_out.status = STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: hw/rtl/ate_div_step.sv
// ---------------------------------------------------------------------------
// ate_div_step
// One registered restoring-division step: shift in a dividend bit, trial
// subtract the divisor, keep one quotient bit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ate_div_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ate_pkg::t_div_beat i_beat,
    output logic               o_valid,
    output ate_pkg::t_div_beat o_beat
);
    import ate_pkg::*;

    logic [DW:0]   w_trial;
    logic [DW+1:0] w_diff;
    logic          w_ge;
    t_div_beat     n_beat;
    logic          r_valid;
    t_div_beat     r_beat;

    // Trial subtract
    always_comb begin
        w_trial = {i_beat.rem, i_beat.xlo[QW-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, i_beat.dmag};
        w_ge    = !w_diff[DW+1];
        n_beat      = i_beat;
        n_beat.rem  = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_beat.xlo  = {i_beat.xlo[QW-2:0], 1'b0};
        n_beat.q    = {i_beat.q[QW-2:0], w_ge};
    end

    // Advance valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: hw/rtl/ate_front.sv
// ---------------------------------------------------------------------------
// ate_front
// Edges, products, N and D, the N*K product and the dividend: six stages.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ate_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ate_pkg::t_in_beat    i_beat,
    output logic                 o_valid,
    output ate_pkg::t_front_beat o_beat
);
    import ate_pkg::*;

    logic [5:0] r_v;

    // stage 1: edges
    logic signed [EW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    // stage 2: products
    logic signed [PW-1:0] r_s1x, r_s1y, r_s2x, r_s2y, r_cx, r_cy, r_da, r_db;
    // stage 3: N and D
    logic signed [68:0]   n_n;
    logic signed [DW:0]   n_d;
    logic [NW-1:0]        r_n;
    logic signed [DW:0]   r_d;
    // stage 4: partial products, |D|
    logic signed [DW:0]   n_dneg;
    logic [63:0]          r_p00, r_p10;
    logic [62:0]          r_p01, r_p11;
    logic [34:0]          r_p20;
    logic [33:0]          r_p21;
    logic [DW-1:0]        r_dmag4, r_dmag5;
    logic                 r_inv4, r_inv5, r_zero4, r_zero5;
    // stage 5: partial sums
    logic [97:0]          r_slo;
    logic [66:0]          r_shi;
    // stage 6: dividend
    logic [130:0]         n_num;
    t_front_beat          r_out;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (i_load) begin
                r_v[0] <= i_valid;
            end
            if (i_en) begin
                r_v[5:1] <= r_v[4:0];
            end
        end
    end

    // Form edges relative to the first vertex
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_e1x <= EW'(i_beat.vertex_b_x) - EW'(i_beat.vertex_a_x);
            r_e1y <= EW'(i_beat.vertex_b_y) - EW'(i_beat.vertex_a_y);
            r_e2x <= EW'(i_beat.vertex_c_x) - EW'(i_beat.vertex_a_x);
            r_e2y <= EW'(i_beat.vertex_c_y) - EW'(i_beat.vertex_a_y);
        end
    end

    // Multiply edge components
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1x <= r_e1x * r_e1x;
            r_s1y <= r_e1y * r_e1y;
            r_s2x <= r_e2x * r_e2x;
            r_s2y <= r_e2y * r_e2y;
            r_cx  <= r_e1x * r_e2x;
            r_cy  <= r_e1y * r_e2y;
            r_da  <= r_e1x * r_e2y;
            r_db  <= r_e2x * r_e1y;
        end
    end

    // Sum into N and D; N is a nonnegative quadratic form
    always_comb begin
        n_n = 69'(r_s1x) + 69'(r_s1y) + 69'(r_s2x) + 69'(r_s2y)
            - 69'(r_cx) - 69'(r_cy);
        n_d = (DW+1)'(r_da) - (DW+1)'(r_db);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n <= n_n[NW-1:0];
            r_d <= n_d;
        end
    end

    // Split N*K into partial products, take |D|
    assign n_dneg = -r_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00   <= r_n[31:0]  * INV_SQRT3_Q63[31:0];
            r_p01   <= r_n[31:0]  * INV_SQRT3_Q63[62:32];
            r_p10   <= r_n[63:32] * INV_SQRT3_Q63[31:0];
            r_p11   <= r_n[63:32] * INV_SQRT3_Q63[62:32];
            r_p20   <= r_n[66:64] * INV_SQRT3_Q63[31:0];
            r_p21   <= r_n[66:64] * INV_SQRT3_Q63[62:32];
            r_dmag4 <= r_d[DW] ? n_dneg[DW-1:0] : r_d[DW-1:0];
            r_inv4  <= r_d[DW];
            r_zero4 <= (r_d == '0);
        end
    end

    // Reduce partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_slo   <= 98'(r_p00) + {3'b000, r_p01, 32'd0} + {2'b00, r_p10, 32'd0};
            r_shi   <= 67'(r_p11) + 67'(r_p20) + {1'b0, r_p21, 32'd0};
            r_dmag5 <= r_dmag4;
            r_inv5  <= r_inv4;
            r_zero5 <= r_zero4;
        end
    end

    // Add the rounding half and drop the 2^30 scale
    assign n_num = 131'(r_slo) + {r_shi, 64'd0} + {36'd0, r_dmag5, 29'd0};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x    <= n_num[130:30];
            r_out.dmag <= r_dmag5;
            r_out.inv  <= r_inv5;
            r_out.zero <= r_zero5;
        end
    end

    assign o_valid = r_v[5];
    assign o_beat  = r_out;

endmodule

FILE: hw/rtl/ate_divider.sv
// ---------------------------------------------------------------------------
// ate_divider
// Overflow check and a 63-stage restoring divider: x / |D|.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ate_divider (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  ate_pkg::t_front_beat i_beat,
    output logic                 o_valid,
    output ate_pkg::t_div_beat   o_beat
);
    import ate_pkg::*;

    logic      w_ovf;
    logic      r_valid;
    t_div_beat r_beat;
    logic      w_valid [QW+1];
    t_div_beat w_beat  [QW+1];

    // Quotient of 2^63 or more saturates; start remainder at the top bits
    assign w_ovf = DW'(i_beat.x[XW-1:QW]) >= i_beat.dmag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat.rem  <= w_ovf ? '0 : DW'(i_beat.x[XW-1:QW]);
            r_beat.xlo  <= i_beat.x[QW-1:0];
            r_beat.q    <= '0;
            r_beat.dmag <= i_beat.dmag;
            r_beat.inv  <= i_beat.inv;
            r_beat.zero <= i_beat.zero;
            r_beat.ovf  <= w_ovf;
        end
    end

    assign w_valid[0] = r_valid;
    assign w_beat[0]  = r_beat;

    // One quotient bit per stage
    for (genvar g = 0; g < QW; g++) begin : g_step
        ate_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (w_valid[g]),
            .i_beat  (w_beat[g]),
            .o_valid (w_valid[g+1]),
            .o_beat  (w_beat[g+1])
        );
    end

    assign o_valid = w_valid[QW];
    assign o_beat  = w_beat[QW];

endmodule

FILE: hw/rtl/ate_checker.sv
// ---------------------------------------------------------------------------
// ate_checker
// Port-level checks of the triangle energy block, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "amips_triangle_energy_defines.svh"

module ate_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input ate_pkg::t_out_beat o_out_data
);
    import ate_pkg::*;

    logic        w_stall;
    logic [66:0] w_out_word;
    logic        w_degen;
    logic        w_ok;
    logic        w_sat;
    logic        w_at_max;
    logic        w_at_min;

    // Decode the result beat
    assign w_stall    = o_out_valid && !i_out_ready;
    assign w_out_word = {o_out_valid, o_out_data};
    assign w_degen    = o_out_valid && (o_out_data.status == STATUS_DEGEN);
    assign w_ok       = o_out_valid && (o_out_data.status == STATUS_OK);
    assign w_sat      = o_out_valid && (o_out_data.status == STATUS_SAT);
    assign w_at_max   = (o_out_data.energy == ENERGY_MAX);
    assign w_at_min   = (o_out_data.energy == ENERGY_MIN);

    // Hold a stalled result beat
    `ATE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, $stable(w_out_word), "held beat changed")

    // Accept input whenever no result is waiting
    `ATE_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, !o_out_valid, o_in_ready, "input held off")

    // Degenerate triangles report the positive limit
    `ATE_ASSERT_NOW(a_degen_max, i_clk, i_rst_n, w_degen, w_at_max, "degenerate beat off max")

    // An unsaturated result never reaches the negative limit
    `ATE_ASSERT_NOW(a_ok_range, i_clk, i_rst_n, w_ok, !w_at_min, "ok beat at negative limit")

    // Saturated results sit at one of the two limits
    `ATE_ASSERT_NOW(a_sat_limit, i_clk, i_rst_n, w_sat, w_at_max || w_at_min, "saturated off limit")

endmodule

bind amips_triangle_energy ate_checker u_ate_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
